@@ sv/siph_pkg.sv @@
// Shared types, constants and the SipRound function of the SipHash-2-4 core.
package siph_pkg;

   localparam logic [63:0] SIP_C0 = 64'h736F_6D65_7073_6575;
   localparam logic [63:0] SIP_C1 = 64'h646F_7261_6E64_6F6D;
   localparam logic [63:0] SIP_C2 = 64'h6C79_6765_6E65_7261;
   localparam logic [63:0] SIP_C3 = 64'h7465_6462_7974_6573;
   localparam logic [63:0] FINAL_XOR = 64'h0000_0000_0000_00FF;

   // Register indexes on the CSR port.
   localparam logic CSR_KEY_LOW  = 1'b0;
   localparam logic CSR_KEY_HIGH = 1'b1;

   // Finalization pipeline layout.
   localparam int unsigned STAGE_COUNT     = 8;
   localparam int unsigned STAGE_ABSORB_A  = 1;
   localparam int unsigned STAGE_ABSORB_B  = 2;
   localparam int unsigned STAGE_TAIL_DONE = 4;

   typedef struct packed {
      logic [63:0] v0;
      logic [63:0] v1;
      logic [63:0] v2;
      logic [63:0] v3;
   } sip_state_type;

   // One finalization job: state plus what is still owed to it.
   typedef struct packed {
      sip_state_type v;
      logic [63:0]   word;        // word whose compression may still be running
      logic [63:0]   tail;        // tail word with length in the top byte
      logic [1:0]    rounds_left; // rounds of that word compression not yet done
   } sip_job_type;

   function automatic sip_state_type sip_round(input sip_state_type s);
      sip_state_type r;
      logic [63:0] a0;
      logic [63:0] a1;
      logic [63:0] a2;
      logic [63:0] a3;
      a0 = s.v0 + s.v1;
      a1 = {s.v1[50:0], s.v1[63:51]} ^ a0;
      a0 = {a0[31:0], a0[63:32]};
      a2 = s.v2 + s.v3;
      a3 = {s.v3[47:0], s.v3[63:48]} ^ a2;
      a0 = a0 + a3;
      a3 = {a3[42:0], a3[63:43]} ^ a0;
      a2 = a2 + a1;
      a1 = {a1[46:0], a1[63:47]} ^ a2;
      a2 = {a2[31:0], a2[63:32]};
      r.v0 = a0;
      r.v1 = a1;
      r.v2 = a2;
      r.v3 = a3;
      return r;
   endfunction

endpackage

@@ sv/siph_absorb.sv @@
// Message state: key registers, byte packing and word compression.
module siph_absorb (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic               csr_index,
   input  logic [63:0]        csr_wdata,
   input  logic               req_fire,
   input  logic [7:0]         req_data_byte,
   input  logic               req_byte_present,
   input  logic               req_last,
   output siph_pkg::sip_job_type launch_job
);
   import siph_pkg::*;

   logic [63:0]   key_low_ff, key_low_in;
   logic [63:0]   key_high_ff, key_high_in;
   sip_state_type av_ff, av_in;
   logic [1:0]    rnd_ff, rnd_in;
   logic [63:0]   word_ff, word_in;
   logic [63:0]   buf_ff, buf_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic [7:0]    len_ff, len_in;
   logic          in_message_ff, in_message_in;

   sip_state_type bv, jv, run_v, rv;
   logic [63:0]   bbuf, pbuf, abuf, bword, jword;
   logic [2:0]    bcnt, pcnt;
   logic [7:0]    blen, plen;
   logic [1:0]    brnd, jrnd, run_rnd;
   logic          full;

   // Background compression: one round per cycle while rounds are owed.
   always_comb begin
      rv = sip_round(av_ff);
      run_v = av_ff;
      run_rnd = rnd_ff;
      if (rnd_ff != 2'd0) begin
         run_v = rv;
         run_rnd = rnd_ff - 2'd1;
         if (rnd_ff == 2'd1) begin
            run_v.v0 = rv.v0 ^ word_ff;
         end
      end
   end

   always_comb begin
      if (in_message_ff) begin
         bv = av_ff;
         bbuf = buf_ff;
         bcnt = cnt_ff;
         blen = len_ff;
         brnd = rnd_ff;
         bword = word_ff;
      end else begin
         bv.v0 = key_low_ff ^ SIP_C0;
         bv.v1 = key_high_ff ^ SIP_C1;
         bv.v2 = key_low_ff ^ SIP_C2;
         bv.v3 = key_high_ff ^ SIP_C3;
         bbuf = '0;
         bcnt = '0;
         blen = '0;
         brnd = '0;
         bword = '0;
      end

      pbuf = bbuf;
      for (int i = 0; i < 8; i++) begin
         if (req_byte_present && bcnt == 3'(i)) begin
            pbuf[i*8 +: 8] = req_data_byte;
         end
      end
      full = req_byte_present && (bcnt == 3'd7);
      pcnt = bcnt + {2'b00, req_byte_present};
      plen = blen + {7'b0, req_byte_present};

      jv = bv;
      jrnd = brnd;
      jword = bword;
      if (full) begin
         jv.v3 = bv.v3 ^ pbuf;
         jrnd = 2'd2;
         jword = pbuf;
      end
      abuf = full ? 64'd0 : pbuf;

      launch_job.v = jv;
      launch_job.word = jword;
      launch_job.tail = {plen, abuf[55:0]};
      launch_job.rounds_left = jrnd;
   end

   always_comb begin
      key_low_in = key_low_ff;
      key_high_in = key_high_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_KEY_LOW:  key_low_in = csr_wdata;
            CSR_KEY_HIGH: key_high_in = csr_wdata;
            default:      key_low_in = key_low_ff;
         endcase
      end

      av_in = run_v;
      rnd_in = run_rnd;
      word_in = word_ff;
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      len_in = len_ff;
      in_message_in = in_message_ff;
      if (req_fire) begin
         if (req_last) begin
            // state handed to the finalization job
            rnd_in = '0;
            buf_in = '0;
            cnt_in = '0;
            len_in = '0;
            in_message_in = 1'b0;
         end else begin
            if (!in_message_ff || full) begin
               av_in = jv;
               rnd_in = jrnd;
            end
            word_in = jword;
            buf_in = abuf;
            cnt_in = pcnt;
            len_in = plen;
            in_message_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff <= '0;
         key_high_ff <= '0;
         rnd_ff <= '0;
         buf_ff <= '0;
         cnt_ff <= '0;
         len_ff <= '0;
         in_message_ff <= 1'b0;
      end else begin
         key_low_ff <= key_low_in;
         key_high_ff <= key_high_in;
         rnd_ff <= rnd_in;
         buf_ff <= buf_in;
         cnt_ff <= cnt_in;
         len_ff <= len_in;
         in_message_ff <= in_message_in;
      end
   end

   always_ff @(posedge clock) begin
      av_ff <= av_in;
      word_ff <= word_in;
   end

`ifndef SYNTHESIS
   a_word_engine_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_byte_present && in_message_ff && cnt_ff == 3'd7) |-> (rnd_ff == 2'd0))
      else $error("word completed while previous compression still running");
   a_closed_is_clean: assert property (@(posedge clock) disable iff (reset)
      !in_message_ff |-> (cnt_ff == 3'd0 && len_ff == 8'd0 && buf_ff == 64'd0))
      else $error("packing state left over outside a message");
   a_open_on_item: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_last) |=> in_message_ff)
      else $error("message not open after a non-final request");
`endif

endmodule

@@ sv/siph_final_pipe.sv @@
// Finalization pipeline: eight round stages and the result register.
module siph_final_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  launch_valid,
   input  siph_pkg::sip_job_type launch_job,
   output logic                  launch_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [63:0]           rsp_hash_value
);
   import siph_pkg::*;

   sip_job_type              job_ff [0:STAGE_COUNT];
   sip_job_type              job_in [0:STAGE_COUNT];
   logic [STAGE_COUNT+1:0]   valid_ff, valid_in;
   logic [STAGE_COUNT+1:0]   take;
   logic [63:0]              hash_ff, hash_in;

   function automatic sip_job_type stage_apply(input sip_job_type j, input int unsigned idx);
      sip_job_type r;
      logic        do_round;
      r = j;
      do_round = 1'b1;
      if (idx == STAGE_ABSORB_A) begin
         do_round = (j.rounds_left == 2'd2);
      end else if (idx == STAGE_ABSORB_B) begin
         do_round = (j.rounds_left != 2'd0);
      end
      if (do_round) begin
         r.v = sip_round(j.v);
      end
      if (idx == STAGE_ABSORB_B) begin
         if (j.rounds_left != 2'd0) begin
            r.v.v0 = r.v.v0 ^ j.word;
         end
         r.v.v3 = r.v.v3 ^ j.tail;
      end
      if (idx == STAGE_TAIL_DONE) begin
         r.v.v0 = r.v.v0 ^ j.tail;
         r.v.v2 = r.v.v2 ^ FINAL_XOR;
      end
      return r;
   endfunction

   // Bubble-collapsing handshake: a stage loads when empty or draining.
   always_comb begin
      take[STAGE_COUNT+1] = !valid_ff[STAGE_COUNT+1] || rsp_ready;
      for (int k = STAGE_COUNT; k >= 0; k--) begin
         take[k] = !valid_ff[k] || take[k+1];
      end
   end

   assign job_in[0] = launch_job;
   for (genvar k = 1; k <= STAGE_COUNT; k++) begin : g_stage
      assign job_in[k] = stage_apply(job_ff[k-1], k);
   end

   assign hash_in = job_ff[STAGE_COUNT].v.v0 ^ job_ff[STAGE_COUNT].v.v1
                  ^ job_ff[STAGE_COUNT].v.v2 ^ job_ff[STAGE_COUNT].v.v3;

   always_comb begin
      valid_in[0] = take[0] ? launch_valid : valid_ff[0];
      for (int k = 1; k <= STAGE_COUNT + 1; k++) begin
         valid_in[k] = take[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= STAGE_COUNT; k++) begin
         if (take[k]) begin
            job_ff[k] <= job_in[k];
         end
      end
      if (take[STAGE_COUNT+1]) begin
         hash_ff <= hash_in;
      end
   end

   assign launch_ready = take[0];
   assign rsp_valid = valid_ff[STAGE_COUNT+1];
   assign rsp_hash_value = hash_ff;

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !launch_ready |-> (&valid_ff))
      else $error("launch refused with an empty slot in the pipeline");
   a_last_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[STAGE_COUNT] && take[STAGE_COUNT+1]) |=> valid_ff[STAGE_COUNT+1])
      else $error("finished job lost on its way to the result register");
`endif

endmodule

@@ sv/siphash_2_4_keyed_hash_core.sv @@
// Keyed SipHash-2-4 core: byte-serial message in, 64-bit hash out.
// Throughput: one request per cycle for any message length, sustained while rsp_ready drains.
// Path: a closing request passes the launch register, 8 stages and the result register.
// Stalls: the finalization pipeline collapses bubbles and holds up to ten
//   hashes; req_ready drops only when all of them are waiting on rsp_ready.
// Reset: synchronous, active high; clears keys, message state and all valids.
module siphash_2_4_keyed_hash_core (
   input  logic        clock,
   input  logic        reset,
   // configuration writes
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_last,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_hash_value
);
   import siph_pkg::*;

   sip_job_type launch_job;
   logic        launch_ready;
   logic        req_fire;
   logic        launch_valid;

   // Every request is taken as soon as the launch register can move; only
   // requests that end a message actually occupy a pipeline slot.
   assign req_ready = launch_ready;
   assign req_fire = req_valid && req_ready;
   assign launch_valid = req_fire && req_last;

   // Message state. Bytes are packed little-endian; each full word is
   // compressed in the background at one round per cycle, which always
   // finishes well before the next word can fill (eight requests later).
   siph_absorb u_absorb (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_fire         (req_fire),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_last         (req_last),
      .launch_job       (launch_job)
   );

   // Finalization. The job carries whatever rounds of the last word are
   // still owed, then the tail word compression, the 0xFF into v2 and the
   // four closing rounds, each stage doing at most one round.
   siph_final_pipe u_final (
      .clock          (clock),
      .reset          (reset),
      .launch_valid   (launch_valid),
      .launch_job     (launch_job),
      .launch_ready   (launch_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

@@ bench/siphash_2_4_keyed_hash_core_tb.sv @@
// Self-checking bench for the SipHash-2-4 core against a local hash model.
module siphash_2_4_keyed_hash_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import siph_pkg::*;

   // One request as the driver presents it.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       last;
   } hash_request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic        csr_index = CSR_KEY_LOW;
   logic [63:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_byte_present = 1'b0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_hash_value;

   hash_request_type pending_requests[$];  // requests not yet put on the bus
   logic [63:0]      expected_hashes[$];   // hashes owed by the core, oldest first
   int unsigned      mismatch_count = 0;
   bit               steady = 1'b0;        // set: neither side idles

   // Local copy of the keys and of the hash state.
   logic [63:0] key_lo = '0;
   logic [63:0] key_hi = '0;
   logic [63:0] sv0 = '0, sv1 = '0, sv2 = '0, sv3 = '0;
   logic [63:0] word_acc = '0;   // partial little-endian word
   logic [2:0]  byte_cnt = '0;   // bytes held in word_acc
   logic [7:0]  msg_len = '0;    // message length mod 256
   bit          msg_open = 1'b0;

   siphash_2_4_keyed_hash_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hash_value   (rsp_hash_value)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------
   // Hash model
   // ---------------------------------------------------------------
   function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned n);
      return (x << n) | (x >> (64 - n));
   endfunction

   // One SipRound on the local state, in the usual ARX order.
   function automatic void sip_mix();
      sv0 = sv0 + sv1; sv1 = rotl64(sv1, 13); sv1 = sv1 ^ sv0; sv0 = rotl64(sv0, 32);
      sv2 = sv2 + sv3; sv3 = rotl64(sv3, 16); sv3 = sv3 ^ sv2;
      sv0 = sv0 + sv3; sv3 = rotl64(sv3, 21); sv3 = sv3 ^ sv0;
      sv2 = sv2 + sv1; sv1 = rotl64(sv1, 17); sv1 = sv1 ^ sv2; sv2 = rotl64(sv2, 32);
   endfunction

   function automatic void compress_word(input logic [63:0] m);
      sv3 = sv3 ^ m;
      sip_mix();
      sip_mix();
      sv0 = sv0 ^ m;
   endfunction

   // Folds one accepted request into the model; returns 1 with the digest
   // when the request closes a message.
   function automatic bit absorb_request(input hash_request_type rq,
                                         output logic [63:0] digest);
      digest = '0;
      // Any request opens a message if none is open; the key is latched here.
      if (!msg_open) begin
         sv0 = key_lo ^ SIP_C0;
         sv1 = key_hi ^ SIP_C1;
         sv2 = key_lo ^ SIP_C2;
         sv3 = key_hi ^ SIP_C3;
         word_acc = '0;
         byte_cnt = '0;
         msg_len = '0;
         msg_open = 1'b1;
      end
      // Byte first, so a byte on the closing request is part of the hash.
      if (rq.byte_present) begin
         word_acc = word_acc | (64'(rq.data_byte) << (8 * byte_cnt));
         msg_len = msg_len + 8'd1;
         if (byte_cnt == 3'd7) begin
            compress_word(word_acc);
            word_acc = '0;
            byte_cnt = '0;
         end else begin
            byte_cnt = byte_cnt + 3'd1;
         end
      end
      if (!rq.last)
         return 1'b0;
      // Tail word carries the length mod 256 in its top byte.
      compress_word(word_acc | {msg_len, 56'd0});
      sv2 = sv2 ^ FINAL_XOR;
      repeat (4) sip_mix();
      digest = sv0 ^ sv1 ^ sv2 ^ sv3;
      word_acc = '0;
      byte_cnt = '0;
      msg_len = '0;
      msg_open = 1'b0;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // Request driver: pops the pending queue, holds each request until
   // accepted, and idles at random unless the steady stretch is on.
   // The model is advanced at the accepting edge.
   // ---------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      hash_request_type rq;
      logic [63:0]      digest;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            rq = '{data_byte: req_data_byte, byte_present: req_byte_present, last: req_last};
            if (absorb_request(rq, digest))
               expected_hashes.push_back(digest);
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 18)) begin
               rq = pending_requests.pop_front();
               req_valid        <= 1'b1;
               req_data_byte    <= rq.data_byte;
               req_byte_present <= rq.byte_present;
               req_last         <= rq.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response side back-pressure.
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= steady || ($urandom_range(99) >= 18);
   end

   // ---------------------------------------------------------------
   // Response monitor: every accepted hash must match the oldest one owed.
   // ---------------------------------------------------------------
   always @(posedge clock) begin : check_hashes
      logic [63:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_hashes.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected hash, expected none, actual %h", $time, rsp_hash_value);
         end else begin
            want = expected_hashes.pop_front();
            if (rsp_hash_value !== want) begin
               mismatch_count++;
               $display("%0t: hash_value mismatch, expected %h, actual %h",
                        $time, want, rsp_hash_value);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   task automatic push_request(input logic [7:0] b, input logic present, input logic closes);
      pending_requests.push_back('{data_byte: b, byte_present: present, last: closes});
   endtask

   // Key writes land at the edge that samples the write strobe; the model follows at once since
   // nothing is in flight when this is called.
   task automatic write_key(input logic idx, input logic [63:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_KEY_LOW)
         key_lo = value;
      else
         key_hi = value;
      @(negedge clock);
   endtask

   // Polls on the falling edge so the check never races the clocked blocks.
   // The extra cycles cover a core still finishing after the last hash.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_hashes.size() != 0);
      repeat (12) @(negedge clock);
   endtask

   // A random message; closes on its last byte or on a byte-less end,
   // may be left open, and is sprinkled with requests that carry nothing.
   task automatic queue_message(input int unsigned nbytes, input bit leave_open);
      bit end_on_byte;
      end_on_byte = (nbytes != 0) && $urandom_range(1);
      for (int unsigned i = 0; i < nbytes; i++) begin
         if ($urandom_range(99) < 4)
            push_request(8'($urandom), 1'b0, 1'b0);
         push_request(8'($urandom), 1'b1,
                      end_on_byte && !leave_open && (i == nbytes - 1));
      end
      if (!leave_open && !end_on_byte)
         push_request(8'($urandom), 1'b0, 1'b1);
   endtask

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin : run_test
      int unsigned target;
      int unsigned nbytes;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: standard test key 00..0f.
      write_key(CSR_KEY_LOW,  64'h0706_0504_0302_0100);
      write_key(CSR_KEY_HIGH, 64'h0f0e_0d0c_0b0a_0908);
      push_request(8'h00, 1'b0, 1'b1);              // empty message
      push_request(8'hA5, 1'b0, 1'b0);              // nothing carried, opens message
      push_request(8'h5A, 1'b0, 1'b1);              // ... then ends it empty
      push_request(8'hFF, 1'b1, 1'b1);              // byte and end together
      for (int i = 0; i < 8; i++)                   // exactly one full word
         push_request((i % 2) ? 8'hFF : 8'h00, 1'b1, i == 7);
      for (int i = 0; i < 7; i++)                   // seven bytes, end without a byte
         push_request(8'(i * 37 + 1), 1'b1, 1'b0);
      push_request(8'h00, 1'b0, 1'b1);
      // Open a message, change the key mid-message: old key must stay in force.
      push_request(8'h00, 1'b0, 1'b0);
      push_request(8'h80, 1'b1, 1'b0);
      push_request(8'h01, 1'b1, 1'b0);
      wait_idle();
      write_key(CSR_KEY_LOW,  '1);
      write_key(CSR_KEY_HIGH, '1);
      push_request(8'h7F, 1'b1, 1'b1);
      push_request(8'hFF, 1'b1, 1'b1);              // first message under all-ones key
      wait_idle();

      // Random phases, each under its own key; odd phases leave a message
      // open across the following key write. Phase 3 runs without idling.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_key(CSR_KEY_LOW,  '0);
               write_key(CSR_KEY_HIGH, '0);
            end
            1: write_key(CSR_KEY_HIGH, '1);
            default: begin
               if ($urandom_range(3) != 0)
                  write_key(CSR_KEY_LOW, {$urandom, $urandom});
               write_key(CSR_KEY_HIGH, {$urandom, $urandom});
            end
         endcase
         steady = (phase == 3);
         target = pending_requests.size() + 330;
         // Phases 2 and 4 include one message long enough to wrap the length byte.
         if (phase == 2 || phase == 4)
            queue_message($urandom_range(300, 256), 1'b0);
         while (pending_requests.size() < target) begin
            if ($urandom_range(99) < 75)
               nbytes = $urandom_range(24);
            else
               nbytes = $urandom_range(80, 25);
            queue_message(nbytes, 1'b0);
         end
         if (phase % 2 == 1)
            queue_message($urandom_range(10, 1), 1'b1);
         wait_idle();
      end
      steady = 1'b0;

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_hashes.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog.
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
